FILE: src/bvsl_pkg.sv
// ----------------------------------------------------------------------------
// bvsl_pkg
// Shared constants and types for the body velocity slew limiter.
// ----------------------------------------------------------------------------
package bvsl_pkg;

  localparam int ACC_W     = 24;
  localparam int TIME_W    = 24;
  localparam int TIME_FRAC = 20;
  localparam int IDX_W     = 8;
  localparam int SQ_W      = 2 * ACC_W;
  localparam int BUDGET_W  = TIME_W + ACC_W;

  localparam logic [ACC_W-1:0] ACC_RESET = 24'd65536;

  localparam logic [IDX_W-1:0] REG_LIN_ACCEL = 8'd0;
  localparam logic [IDX_W-1:0] REG_ANG_ACCEL = 8'd1;

  typedef enum logic [1:0] {
    PATH_REACHED = 2'd0,
    PATH_STOP    = 2'd1,
    PATH_PARTIAL = 2'd2
  } path_t;

endpackage

FILE: src/bvsl_front.sv
// ----------------------------------------------------------------------------
// bvsl_front
// Input stages: differences, squared linear change and the reversal test.
// ----------------------------------------------------------------------------
module bvsl_front #(
  parameter int VW = 24,
  localparam int CW = 9 * VW + 3 + 2 * bvsl_pkg::ACC_W + bvsl_pkg::TIME_W,
  localparam int RW = 2 * VW + 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [VW-1:0]           cur_vx,
  input  logic signed [VW-1:0]           cur_vy,
  input  logic signed [VW-1:0]           cur_wz,
  input  logic signed [VW-1:0]           tgt_vx,
  input  logic signed [VW-1:0]           tgt_vy,
  input  logic signed [VW-1:0]           tgt_wz,
  input  logic [bvsl_pkg::TIME_W-1:0]    elapsed,
  input  logic [bvsl_pkg::ACC_W-1:0]     lin_accel,
  input  logic [bvsl_pkg::ACC_W-1:0]     ang_accel,
  output logic                           out_valid,
  output logic                           out_stop,
  output logic [RW-1:0]                  radicand,
  output logic [CW-1:0]                  carry
);
  import bvsl_pkg::*;

  typedef struct packed {
    logic signed [VW-1:0] cx, cy, cz, tx, ty, tz;
    logic signed [VW:0]   dx, dy, dz;
    logic [TIME_W-1:0]    e;
    logic [ACC_W-1:0]     al, aa;
  } carry_t;

  localparam int PW  = 2 * VW;
  localparam int DLW = 2 * VW + 1;
  localparam int HW  = ACC_W;
  localparam int PLW = DLW + HW + 1;
  localparam int PZW = PW + HW + 1;
  localparam int SW  = DLW + SQ_W + 2;

  // stage 1: register, differences, zero-target flag
  logic   v1, z1;
  carry_t k1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      k1.cx <= cur_vx;
      k1.cy <= cur_vy;
      k1.cz <= cur_wz;
      k1.tx <= tgt_vx;
      k1.ty <= tgt_vy;
      k1.tz <= tgt_wz;
      k1.dx <= (VW+1)'(tgt_vx) - (VW+1)'(cur_vx);
      k1.dy <= (VW+1)'(tgt_vy) - (VW+1)'(cur_vy);
      k1.dz <= (VW+1)'(tgt_wz) - (VW+1)'(cur_wz);
      k1.e  <= elapsed;
      k1.al <= (lin_accel == '0) ? ACC_W'(1) : lin_accel;
      k1.aa <= (ang_accel == '0) ? ACC_W'(1) : ang_accel;
      z1    <= (tgt_vx == '0) && (tgt_vy == '0) && (tgt_wz == '0);
    end
  end

  // stage 2: products and squares
  logic signed [PW-1:0]    pxx_c, pyy_c, pzz_c;
  logic signed [2*VW+1:0]  sqx_c, sqy_c;
  logic [SQ_W-1:0]         asq_c, lsq_c;
  always_comb begin
    pxx_c = k1.cx * k1.tx;
    pyy_c = k1.cy * k1.ty;
    pzz_c = k1.cz * k1.tz;
    sqx_c = k1.dx * k1.dx;
    sqy_c = k1.dy * k1.dy;
    asq_c = k1.aa * k1.aa;
    lsq_c = k1.al * k1.al;
  end

  logic                 v2, z2;
  carry_t               k2;
  logic signed [PW-1:0] pxx2, pyy2, pzz2;
  logic [DLW-1:0]       sqx2, sqy2;
  logic [SQ_W-1:0]      asq2, lsq2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      z2   <= z1;
      k2   <= k1;
      pxx2 <= pxx_c;
      pyy2 <= pyy_c;
      pzz2 <= pzz_c;
      sqx2 <= sqx_c[DLW-1:0];
      sqy2 <= sqy_c[DLW-1:0];
      asq2 <= asq_c;
      lsq2 <= lsq_c;
    end
  end

  // stage 3: linear dot product and radicand
  logic                  v3, z3;
  carry_t                k3;
  logic signed [DLW-1:0] dl3;
  logic signed [PW-1:0]  pzz3;
  logic [SQ_W-1:0]       asq3, lsq3;
  logic [RW-1:0]         rad3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      z3   <= z2;
      k3   <= k2;
      dl3  <= DLW'(pxx2) + DLW'(pyy2);
      pzz3 <= pzz2;
      asq3 <= asq2;
      lsq3 <= lsq2;
      rad3 <= RW'(sqx2) + RW'(sqy2);
    end
  end

  // stage 4: weighting by squared accelerations, split in halves
  logic signed [PLW-1:0] alo_c, ahi_c;
  logic signed [PZW-1:0] blo_c, bhi_c;
  always_comb begin
    alo_c = dl3 * $signed({1'b0, asq3[HW-1:0]});
    ahi_c = dl3 * $signed({1'b0, asq3[SQ_W-1:HW]});
    blo_c = pzz3 * $signed({1'b0, lsq3[HW-1:0]});
    bhi_c = pzz3 * $signed({1'b0, lsq3[SQ_W-1:HW]});
  end

  logic                  v4, z4;
  carry_t                k4;
  logic [RW-1:0]         rad4;
  logic signed [PLW-1:0] alo4, ahi4;
  logic signed [PZW-1:0] blo4, bhi4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      z4   <= z3;
      k4   <= k3;
      rad4 <= rad3;
      alo4 <= alo_c;
      ahi4 <= ahi_c;
      blo4 <= blo_c;
      bhi4 <= bhi_c;
    end
  end

  // stage 5: recombine halves
  logic                 v5, z5;
  carry_t               k5;
  logic [RW-1:0]        rad5;
  logic signed [SW-1:0] sa5, sb5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      z5   <= z4;
      k5   <= k4;
      rad5 <= rad4;
      sa5  <= SW'(alo4) + (SW'(ahi4) <<< HW);
      sb5  <= SW'(blo4) + (SW'(bhi4) <<< HW);
    end
  end

  // stage 6: sign of the weighted dot product
  logic signed [SW-1:0] sum5;
  assign sum5 = sa5 + sb5;

  logic          v6, stop6;
  carry_t        k6;
  logic [RW-1:0] rad6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      stop6 <= z5 || sum5[SW-1];
      k6    <= k5;
      rad6  <= rad5;
    end
  end

  assign out_valid = v6;
  assign out_stop  = stop6;
  assign radicand  = rad6;
  assign carry     = k6;

endmodule

FILE: src/bvsl_sqrt.sv
// ----------------------------------------------------------------------------
// bvsl_sqrt
// Pipelined square root, one root bit per stage, rounded up at the end.
// ----------------------------------------------------------------------------
module bvsl_sqrt #(
  parameter int RW = 50,
  parameter int QW = 25,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] radicand,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] root,
  output logic [SW-1:0] out_side
);

  logic [QW-1:0] vld;
  logic [RW-1:0] rem      [QW];
  logic [QW-1:0] rt       [QW];
  logic [SW-1:0] sd       [QW];
  logic [RW-1:0] src_rem  [QW];
  logic [QW-1:0] src_rt   [QW];
  logic [SW-1:0] src_sd   [QW];
  logic [RW-1:0] rem_next [QW];
  logic [QW-1:0] rt_next  [QW];

  always_comb begin
    src_rem[0] = radicand;
    src_rt[0]  = '0;
    src_sd[0]  = side;
    for (int k = 1; k < QW; k++) begin
      src_rem[k] = rem[k-1];
      src_rt[k]  = rt[k-1];
      src_sd[k]  = sd[k-1];
    end
  end

  // try bit b: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
  always_comb begin
    logic [RW:0] trial;
    int          b;
    for (int k = 0; k < QW; k++) begin
      b     = QW - 1 - k;
      trial = ((RW+1)'(src_rt[k]) << (b + 1)) + ((RW+1)'(1) << (2 * b));
      if ({1'b0, src_rem[k]} >= trial) begin
        rem_next[k] = src_rem[k] - trial[RW-1:0];
        rt_next[k]  = src_rt[k] | (QW'(1) << b);
      end else begin
        rem_next[k] = src_rem[k];
        rt_next[k]  = src_rt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[QW-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem[k] <= rem_next[k];
        rt[k]  <= rt_next[k];
        sd[k]  <= src_sd[k];
      end
    end
  end

  // round up when a remainder is left
  logic          ov;
  logic [QW-1:0] root_q;
  logic [SW-1:0] side_q;
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0;
    else if (en) ov <= vld[QW-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      root_q <= rt[QW-1] + QW'(rem[QW-1] != '0);
      side_q <= sd[QW-1];
    end
  end

  assign out_valid = ov;
  assign root      = root_q;
  assign out_side  = side_q;

endmodule

FILE: src/bvsl_div.sv
// ----------------------------------------------------------------------------
// bvsl_div
// Pipelined restoring divider for the progress fraction, one bit per stage.
// ----------------------------------------------------------------------------
module bvsl_div #(
  parameter int NUMW = 25,
  parameter int PB   = 24,
  parameter int SW   = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [NUMW-1:0]                num,
  input  logic [bvsl_pkg::BUDGET_W-1:0]  budget,
  input  logic [SW-1:0]                  side,
  output logic                           out_valid,
  output logic                           reached,
  output logic [PB-1:0]                  quot,
  output logic [SW-1:0]                  out_side
);
  import bvsl_pkg::*;

  localparam int LW = NUMW + TIME_FRAC;
  localparam int MW = (LW > BUDGET_W) ? LW : BUDGET_W;

  // setup stage: limit, early-reach test, initial remainder
  logic [LW-1:0] lim_c;
  logic          rch_c;
  assign lim_c = {num, {TIME_FRAC{1'b0}}};
  assign rch_c = MW'(lim_c) <= MW'(budget);

  logic          v0, rch0;
  logic [LW-1:0] lim0, rem0;
  logic [SW-1:0] sd0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rch0 <= rch_c;
      lim0 <= lim_c;
      rem0 <= rch_c ? '0 : LW'(budget);
      sd0  <= side;
    end
  end

  logic [PB-1:0] vld;
  logic [LW-1:0] rem      [PB];
  logic [LW-1:0] lim      [PB];
  logic [PB-1:0] q        [PB];
  logic          rch      [PB];
  logic [SW-1:0] sd       [PB];
  logic [LW-1:0] src_rem  [PB];
  logic [LW-1:0] src_lim  [PB];
  logic [PB-1:0] src_q    [PB];
  logic          src_rch  [PB];
  logic [SW-1:0] src_sd   [PB];
  logic [LW-1:0] rem_next [PB];
  logic [PB-1:0] q_next   [PB];

  always_comb begin
    src_rem[0] = rem0;
    src_lim[0] = lim0;
    src_q[0]   = '0;
    src_rch[0] = rch0;
    src_sd[0]  = sd0;
    for (int k = 1; k < PB; k++) begin
      src_rem[k] = rem[k-1];
      src_lim[k] = lim[k-1];
      src_q[k]   = q[k-1];
      src_rch[k] = rch[k-1];
      src_sd[k]  = sd[k-1];
    end
  end

  always_comb begin
    logic [LW:0] r2;
    for (int k = 0; k < PB; k++) begin
      r2 = {src_rem[k], 1'b0};
      if (r2 >= {1'b0, src_lim[k]}) begin
        rem_next[k] = LW'(r2 - {1'b0, src_lim[k]});
        q_next[k]   = {src_q[k][PB-2:0], 1'b1};
      end else begin
        rem_next[k] = r2[LW-1:0];
        q_next[k]   = {src_q[k][PB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[PB-2:0], v0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < PB; k++) begin
        rem[k] <= rem_next[k];
        lim[k] <= src_lim[k];
        q[k]   <= q_next[k];
        rch[k] <= src_rch[k];
        sd[k]  <= src_sd[k];
      end
    end
  end

  assign out_valid = vld[PB-1];
  assign reached   = rch[PB-1];
  assign quot      = q[PB-1];
  assign out_side  = sd[PB-1];

endmodule

FILE: src/body_velocity_slew_limiter.sv
// ----------------------------------------------------------------------------
// body_velocity_slew_limiter
// Limits the change of a planar velocity command under two acceleration caps.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every cycle while in_stall is
// low. The latency is set by the bit-per-stage square root of the linear
// change (VEL_WIDTH + 2 stages) and the bit-per-stage divider for the
// progress fraction (PROGRESS_BITS + 1 stages). A skid register at the
// output holds one result while out_stall is high; in_stall rises only while
// that skid register is occupied.
module body_velocity_slew_limiter #(
  parameter int VEL_WIDTH     = 24,
  parameter int PROGRESS_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bvsl_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bvsl_pkg::ACC_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VEL_WIDTH-1:0]   cur_vx,
  input  logic signed [VEL_WIDTH-1:0]   cur_vy,
  input  logic signed [VEL_WIDTH-1:0]   cur_wz,
  input  logic signed [VEL_WIDTH-1:0]   tgt_vx,
  input  logic signed [VEL_WIDTH-1:0]   tgt_vy,
  input  logic signed [VEL_WIDTH-1:0]   tgt_wz,
  input  logic [bvsl_pkg::TIME_W-1:0]   elapsed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VEL_WIDTH-1:0]   out_vx,
  output logic signed [VEL_WIDTH-1:0]   out_vy,
  output logic signed [VEL_WIDTH-1:0]   out_wz,
  output logic [1:0]                    path_taken
);
  import bvsl_pkg::*;

  localparam int VW = VEL_WIDTH;
  localparam int QW = VW + 1;
  localparam int RW = 2 * VW + 2;
  localparam int CW = 9 * VW + 3 + 2 * ACC_W + TIME_W;
  localparam int DW = 9 * VW + 4;
  localparam int PB_W = PROGRESS_BITS;

  typedef struct packed {
    logic signed [VW-1:0] cx, cy, cz, tx, ty, tz;
    logic signed [VW:0]   dx, dy, dz;
    logic [TIME_W-1:0]    e;
    logic [ACC_W-1:0]     al, aa;
  } carry_t;

  typedef struct packed {
    logic signed [VW-1:0] cx, cy, cz, tx, ty, tz;
    logic signed [VW:0]   dx, dy, dz;
    logic                 stop;
  } dside_t;

  typedef struct packed {
    logic signed [VW-1:0] vx, vy, vz;
    path_t                path;
  } res_t;

  // configuration registers
  logic [ACC_W-1:0] lin_accel, ang_accel;
  always_ff @(posedge clk) begin
    if (rst) begin
      lin_accel <= ACC_RESET;
      ang_accel <= ACC_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_LIN_ACCEL) lin_accel <= cfg_data;
      else if (cfg_index == REG_ANG_ACCEL) ang_accel <= cfg_data;
    end
  end

  logic skid_valid;
  logic en;
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // front stages
  logic          f_valid, f_stop;
  logic [RW-1:0] f_rad;
  logic [CW-1:0] f_carry;

  bvsl_front #(.VW(VW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .cur_vx    (cur_vx),
    .cur_vy    (cur_vy),
    .cur_wz    (cur_wz),
    .tgt_vx    (tgt_vx),
    .tgt_vy    (tgt_vy),
    .tgt_wz    (tgt_wz),
    .elapsed   (elapsed),
    .lin_accel (lin_accel),
    .ang_accel (ang_accel),
    .out_valid (f_valid),
    .out_stop  (f_stop),
    .radicand  (f_rad),
    .carry     (f_carry)
  );

  // linear change magnitude
  logic          s_valid;
  logic [QW-1:0] s_root;
  logic [CW:0]   s_side;

  bvsl_sqrt #(.RW(RW), .QW(QW), .SW(CW + 1)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .radicand  (f_rad),
    .side      ({f_stop, f_carry}),
    .out_valid (s_valid),
    .root      (s_root),
    .out_side  (s_side)
  );

  carry_t sk;
  logic   s_stop;
  assign sk     = s_side[CW-1:0];
  assign s_stop = s_side[CW];

  // select stage 1: cross products of change and acceleration, elapsed time times each acceleration
  logic [QW-1:0] w_c;
  assign w_c = QW'(sk.dz[VW] ? -sk.dz : sk.dz);

  logic                  v_t1;
  logic [QW-1:0]         len1, w1;
  logic [QW+ACC_W-1:0]   la1, wa1;
  logic [BUDGET_W-1:0]   eal1, eaa1;
  dside_t                ds1;
  always_ff @(posedge clk) begin
    if (rst) v_t1 <= 1'b0;
    else if (en) v_t1 <= s_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      len1 <= s_root;
      w1   <= w_c;
      la1  <= s_root * sk.aa;
      wa1  <= w_c * sk.al;
      eal1 <= sk.e * sk.al;
      eaa1 <= sk.e * sk.aa;
      ds1  <= '{cx: sk.cx, cy: sk.cy, cz: sk.cz, tx: sk.tx, ty: sk.ty, tz: sk.tz,
                dx: sk.dx, dy: sk.dy, dz: sk.dz, stop: s_stop};
    end
  end

  // select stage 2: governing change and time budget
  logic                v_t2;
  logic [QW-1:0]       num2;
  logic [BUDGET_W-1:0] budget2;
  dside_t              ds2;
  always_ff @(posedge clk) begin
    if (rst) v_t2 <= 1'b0;
    else if (en) v_t2 <= v_t1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      num2    <= (la1 >= wa1) ? len1 : w1;
      budget2 <= (la1 >= wa1) ? eal1 : eaa1;
      ds2     <= ds1;
    end
  end

  // progress fraction
  logic          d_valid, d_reached;
  logic [PB_W-1:0] d_quot;
  logic [DW-1:0] d_side;

  bvsl_div #(.NUMW(QW), .PB(PB_W), .SW(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_t2),
    .num       (num2),
    .budget    (budget2),
    .side      (ds2),
    .out_valid (d_valid),
    .reached   (d_reached),
    .quot      (d_quot),
    .out_side  (d_side)
  );

  dside_t ds;
  assign ds = d_side;

  // scale stage: change magnitude times fraction
  logic [QW-1:0] mx_c, my_c, mz_c;
  assign mx_c = QW'(ds.dx[VW] ? -ds.dx : ds.dx);
  assign my_c = QW'(ds.dy[VW] ? -ds.dy : ds.dy);
  assign mz_c = QW'(ds.dz[VW] ? -ds.dz : ds.dz);

  path_t path_c;
  always_comb begin
    priority if (ds.stop) path_c = PATH_STOP;
    else if (d_reached)   path_c = PATH_REACHED;
    else                  path_c = PATH_PARTIAL;
  end

  logic                 v3;
  path_t                path3;
  logic [QW+PB_W-1:0]   px3, py3, pz3;
  logic                 nx3, ny3, nz3;
  logic signed [VW-1:0] cx3, cy3, cz3, tx3, ty3, tz3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= d_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      path3 <= path_c;
      px3   <= mx_c * d_quot;
      py3   <= my_c * d_quot;
      pz3   <= mz_c * d_quot;
      nx3   <= ds.dx[VW];
      ny3   <= ds.dy[VW];
      nz3   <= ds.dz[VW];
      cx3   <= ds.cx;
      cy3   <= ds.cy;
      cz3   <= ds.cz;
      tx3   <= ds.tx;
      ty3   <= ds.ty;
      tz3   <= ds.tz;
    end
  end

  // result assembly
  logic [VW-1:0] sx, sy, sz;
  assign sx = px3[PB_W +: VW];
  assign sy = py3[PB_W +: VW];
  assign sz = pz3[PB_W +: VW];

  res_t res;
  always_comb begin
    res.path = path3;
    unique case (path3)
      PATH_STOP: begin
        res.vx = '0;
        res.vy = '0;
        res.vz = '0;
      end
      PATH_REACHED: begin
        res.vx = tx3;
        res.vy = ty3;
        res.vz = tz3;
      end
      default: begin
        res.vx = nx3 ? (cx3 - sx) : (cx3 + sx);
        res.vy = ny3 ? (cy3 - sy) : (cy3 + sy);
        res.vz = nz3 ? (cz3 - sz) : (cz3 + sz);
      end
    endcase
  end

  // output register and skid
  logic take, arrive;
  assign take   = out_valid && !out_stall;
  assign arrive = v3 && en;

  res_t out_q, skid_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) skid_valid <= 1'b0;
    end else if (arrive) begin
      if (out_valid && !take) skid_valid <= 1'b1;
      else out_valid <= 1'b1;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) out_q <= skid_q;
    end else if (arrive) begin
      if (out_valid && !take) skid_q <= res;
      else out_q <= res;
    end
  end

  assign out_vx     = out_q.vx;
  assign out_vy     = out_q.vy;
  assign out_wz     = out_q.vz;
  assign path_taken = out_q.path;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a transaction while output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled without a stalled output");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_stall |=> !skid_valid)
    else $error("skid did not drain when output was taken");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_q.path == PATH_STOP) |->
      (out_vx == '0) && (out_vy == '0) && (out_wz == '0))
    else $error("stop result carries nonzero velocity");

endmodule
